[design/tdssm_pkg.sv]
`default_nettype none
package tdssm_pkg;

    localparam int CHANNELS_DEF = 256;
    localparam int CHAN_W       = 8;
    localparam int CHAN_SPACE   = 2 ** CHAN_W;
    localparam int CMD_QDEPTH   = 2;
    localparam int RES_QDEPTH   = 2;

    // ternary weight codes; the other two codes mean zero
    localparam logic [1:0] CODE_POS = 2'b01;
    localparam logic [1:0] CODE_NEG = 2'b10;

    localparam logic signed [16:0] SAT_HI = 17'sd127;
    localparam logic signed [16:0] SAT_LO = -17'sd128;

    typedef enum logic {
        K_LOAD = 1'b0,
        K_STEP = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic              kind;
        logic [7:0]        channel;
        logic signed [7:0] x_value;
        logic signed [7:0] weight_a;
        logic signed [7:0] weight_b;
        logic signed [7:0] weight_c;
    } t_in;

    typedef struct packed {
        logic [7:0]        channel_out;
        logic signed [7:0] y_value;
        logic signed [7:0] state_value;
    } t_out;

    // queued command, weights already decoded
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        channel;
        logic signed [7:0] x_value;
        logic signed [7:0] w_a;
        logic signed [7:0] w_b;
        logic signed [7:0] w_c;
    } t_cmd;

    function automatic logic signed [7:0] sat8(input logic signed [16:0] v);
        logic signed [7:0] r;
        if (v > SAT_HI) begin
            r = 8'sd127;
        end else if (v < SAT_LO) begin
            r = -8'sd128;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [7:0] decode_w(input logic packed_md,
                                                   input logic signed [7:0] f);
        logic signed [7:0] r;
        if (packed_md) begin
            case (f[1:0])
                CODE_POS: r = 8'sd1;
                CODE_NEG: r = -8'sd1;
                default:  r = 8'sd0;
            endcase
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/tdssm_ram.sv]
`default_nettype none
module tdssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

[design/tdssm_fifo.sv]
`default_nettype none
module tdssm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

[design/tdssm_front.sv]
`default_nettype none
module tdssm_front #(
    parameter int CHANNELS = tdssm_pkg::CHANNELS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_data,
    input  wire logic            i_push,
    input  wire tdssm_pkg::t_in  i_in,
    output logic                 o_full,
    output logic                 o_cmd_push,
    output tdssm_pkg::t_cmd      o_cmd,
    input  wire logic            i_cmd_full
);

    logic r_packed;
    logic in_rng;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_packed <= i_cfg_data;
        end
    end

    // channels past the configured count are taken and dropped
    assign in_rng     = (32'(i_in.channel) < CHANNELS);
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full && in_rng;

    // decode under the mode in force at transfer
    always_comb begin
        o_cmd.kind    = tdssm_pkg::t_kind'(i_in.kind);
        o_cmd.channel = i_in.channel;
        o_cmd.x_value = i_in.x_value;
        o_cmd.w_a     = tdssm_pkg::decode_w(r_packed, i_in.weight_a);
        o_cmd.w_b     = tdssm_pkg::decode_w(r_packed, i_in.weight_b);
        o_cmd.w_c     = tdssm_pkg::decode_w(r_packed, i_in.weight_c);
    end

endmodule
`default_nettype wire

[design/tdssm_back.sv]
`default_nettype none
module tdssm_back #(
    parameter int DEPTH = tdssm_pkg::CHANNELS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tdssm_pkg::t_cmd  i_cmd,
    input  wire logic             i_cmd_empty,
    output logic                  o_cmd_pop,
    output tdssm_pkg::t_out       o_res,
    output logic                  o_res_push,
    input  wire logic             i_res_full
);

    tdssm_pkg::t_bstate r_state, n_state;

    logic [7:0]        r_ch, n_ch;
    logic signed [7:0] r_x, n_x;
    logic signed [7:0] r_hn, n_hn;
    logic signed [7:0] r_c, n_c;
    logic              r_hv, n_hv;
    logic [DEPTH-1:0]  r_sv;

    logic [AW-1:0]     head_addr, s_addr;
    logic              s_we, w_we;
    logic [7:0]        s_wdata, s_rdata;
    logic [23:0]       w_rdata;

    logic signed [7:0]  h, rd_a, rd_b, rd_c, hn_calc;
    logic signed [15:0] p_a, p_b, p_c;
    logic signed [16:0] p_sum;

    assign head_addr = i_cmd.channel[AW-1:0];

    tdssm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_addr  (s_addr),
        .i_wdata (s_wdata),
        .o_rdata (s_rdata)
    );

    tdssm_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (head_addr),
        .i_wdata ({i_cmd.w_a, i_cmd.w_b, i_cmd.w_c}),
        .o_rdata (w_rdata)
    );

    // never-written state reads as zero
    assign h       = r_hv ? $signed(s_rdata) : 8'sd0;
    assign rd_a    = $signed(w_rdata[23:16]);
    assign rd_b    = $signed(w_rdata[15:8]);
    assign rd_c    = $signed(w_rdata[7:0]);
    assign p_a     = rd_a * h;
    assign p_b     = rd_b * r_x;
    assign p_sum   = 17'(p_a) + 17'(p_b);
    assign hn_calc = tdssm_pkg::sat8(p_sum);
    assign p_c     = r_c * r_hn;

    always_comb begin
        o_res.channel_out = r_ch;
        o_res.y_value     = tdssm_pkg::sat8(17'(p_c));
        o_res.state_value = r_hn;
    end

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_x        = r_x;
        n_hv       = r_hv;
        n_hn       = r_hn;
        n_c        = r_c;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_we       = 1'b0;
        s_we       = 1'b0;
        s_addr     = head_addr;
        s_wdata    = i_cmd.x_value;
        case (r_state)
            tdssm_pkg::B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == tdssm_pkg::K_LOAD) begin
                        w_we = 1'b1;
                        s_we = 1'b1;
                    end else begin
                        // both RAM reads issue this cycle
                        n_ch    = i_cmd.channel;
                        n_x     = i_cmd.x_value;
                        n_hv    = r_sv[head_addr];
                        n_state = tdssm_pkg::B_CALC;
                    end
                end
            end
            tdssm_pkg::B_CALC: begin
                s_addr  = r_ch[AW-1:0];
                s_we    = 1'b1;
                s_wdata = hn_calc;
                n_hn    = hn_calc;
                n_c     = rd_c;
                n_state = tdssm_pkg::B_EMIT;
            end
            tdssm_pkg::B_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = tdssm_pkg::B_IDLE;
                end
            end
            default: n_state = tdssm_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdssm_pkg::B_IDLE;
            r_sv    <= '0;
        end else begin
            r_state <= n_state;
            if (s_we) begin
                r_sv[s_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
        r_x  <= n_x;
        r_hv <= n_hv;
        r_hn <= n_hn;
        r_c  <= n_c;
    end

`ifndef SYNTH
    a_calc_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdssm_pkg::B_CALC) |-> ($past(r_state) == tdssm_pkg::B_IDLE))
        else $error("calc stage not entered from idle");

    a_calc_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdssm_pkg::B_CALC) |=> (r_state == tdssm_pkg::B_EMIT))
        else $error("calc stage did not hand on to emit");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !i_cmd_empty)
        else $error("command pop while queue empty");

    a_state_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_we && r_state == tdssm_pkg::B_CALC) |=> r_sv[$past(s_addr)])
        else $error("state entry not marked valid after write");
`endif

endmodule
`default_nettype wire

[design/ternary_diagonal_ssm_step_unit.sv]
`default_nettype none
// channel   direction  handshake              payload
// input     in         push / full            i_in  (tdssm_pkg::t_in)
// result    out        empty / pop            o_out (tdssm_pkg::t_out)
// config    in         i_cfg_valid/o_cfg_ready i_cfg_data (packed mode)
//
// A load is handled in the idle state; a step passes through idle (state RAM
// read), calc (a*h + b*x) and emit (c*h'), set by the read-modify-write sequence.
// Reset is synchronous, active low; per-channel valid bits clear at once.
// full rises when the two-entry command queue is full; the back end holds a
// finished step while the two-entry result queue is full.
module ternary_diagonal_ssm_step_unit #(
    parameter int CHANNELS = tdssm_pkg::CHANNELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_data,
    input  wire logic           push,
    output logic                full,
    input  wire tdssm_pkg::t_in i_in,
    output logic                empty,
    input  wire logic           pop,
    output tdssm_pkg::t_out     o_out
);

    localparam int DEPTH = (CHANNELS < tdssm_pkg::CHAN_SPACE) ?
                           CHANNELS : tdssm_pkg::CHAN_SPACE;

    tdssm_pkg::t_cmd front_cmd, back_cmd;
    tdssm_pkg::t_out back_res;
    logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic            res_push, res_full;

    tdssm_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd),
        .i_cmd_full  (cmd_full)
    );

    tdssm_fifo #(
        .WIDTH ($bits(tdssm_pkg::t_cmd)),
        .DEPTH (tdssm_pkg::CMD_QDEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    tdssm_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    tdssm_fifo #(
        .WIDTH ($bits(tdssm_pkg::t_out)),
        .DEPTH (tdssm_pkg::RES_QDEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

[tb/ternary_diagonal_ssm_step_unit_tb.sv]
`timescale 1ns / 1ps
module ternary_diagonal_ssm_step_unit_tb;

    localparam int N_CHAN         = tdssm_pkg::CHANNELS_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 115;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;
    logic push;
    logic full;
    tdssm_pkg::t_in  i_in;
    logic empty;
    logic pop;
    tdssm_pkg::t_out o_out;

    ternary_diagonal_ssm_step_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

    // shadow of the recurrence: per-channel state and decoded weights
    int   chan_state [N_CHAN];
    int   wt_a       [N_CHAN];
    int   wt_b       [N_CHAN];
    int   wt_c       [N_CHAN];
    bit   has_weights[N_CHAN];
    bit   packed_now;

    tdssm_pkg::t_out expected_steps[$];
    int   error_count;
    int   quiet_cycles;
    int   last_chan;
    bit   calm;

    typedef struct {
        bit              cfg_row;
        bit              cfg_value;
        tdssm_pkg::t_in  item;
        bit              known;
        logic [7:0]      y;
        logic [7:0]      h;
    } t_plan_row;

    t_plan_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clamp8(input int v);
        if (v > 127) return 127;
        if (v < -128) return -128;
        return v;
    endfunction

    // decode happens at load time under the mode then in force
    function automatic int weight_of(input logic [7:0] f);
        int r;
        if (packed_now) begin
            case (f[1:0])
                tdssm_pkg::CODE_POS: r = 1;
                tdssm_pkg::CODE_NEG: r = -1;
                default:             r = 0;
            endcase
        end else begin
            r = int'($signed(f));
        end
        return r;
    endfunction

    function automatic void recur_channel(input tdssm_pkg::t_in it, output bit emits,
                                          output tdssm_pkg::t_out res);
        int ch;
        int x;
        int hn;
        int y;
        emits = 1'b0;
        res   = '0;
        ch    = int'(it.channel);
        x     = int'(it.x_value);
        if (ch >= N_CHAN) return;
        if (it.kind == tdssm_pkg::K_LOAD) begin
            wt_a[ch]        = weight_of(it.weight_a);
            wt_b[ch]        = weight_of(it.weight_b);
            wt_c[ch]        = weight_of(it.weight_c);
            chan_state[ch]  = x;
            has_weights[ch] = 1'b1;
        end else begin
            hn             = clamp8(wt_a[ch] * chan_state[ch] + wt_b[ch] * x);
            chan_state[ch] = hn;
            y              = clamp8(wt_c[ch] * hn);
            res.channel_out = ch[7:0];
            res.y_value     = y[7:0];
            res.state_value = hn[7:0];
            emits           = 1'b1;
        end
    endfunction

    task automatic plan_item(input tdssm_pkg::t_kind k, input int ch, input int x,
                             input int a, input int b, input int c,
                             input bit known = 1'b0, input int y = 0, input int h = 0);
        t_plan_row r;
        r.cfg_row       = 1'b0;
        r.cfg_value     = 1'b0;
        r.item.kind     = k;
        r.item.channel  = ch[7:0];
        r.item.x_value  = x[7:0];
        r.item.weight_a = a[7:0];
        r.item.weight_b = b[7:0];
        r.item.weight_c = c[7:0];
        r.known         = known;
        r.y             = y[7:0];
        r.h             = h[7:0];
        directed_rows.push_back(r);
    endtask

    task automatic plan_cfg(input bit mode);
        t_plan_row r;
        r         = '{default: '0};
        r.cfg_row   = 1'b1;
        r.cfg_value = mode;
        directed_rows.push_back(r);
    endtask

    // one item through the input queue; the prediction is taken at the transfer edge
    task automatic send_item(input tdssm_pkg::t_in it, input bit known = 1'b0,
                             input logic [7:0] y_known = '0, input logic [7:0] h_known = '0);
        bit              emits;
        tdssm_pkg::t_out res;
        if (!calm && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        recur_channel(it, emits, res);
        if (emits) begin
            if (known) begin
                res.y_value     = y_known;
                res.state_value = h_known;
            end
            expected_steps.push_back(res);
        end
    endtask

    // only while idle: drain results, let trailing loads retire, then write
    task automatic write_mode(input bit mode);
        push <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        packed_now = mode;
    endtask

    function automatic logic [7:0] pick_weight();
        int v;
        if (packed_now) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0, 1:    v = int'($urandom_range(0, 4)) - 2;
            2:       v = $urandom_range(0, 255);
            default: v = $urandom_range(0, 1) ? 127 : -128;
        endcase
        return v[7:0];
    endfunction

    task automatic random_item(output tdssm_pkg::t_in it);
        int ch;
        it = '0;
        case ($urandom_range(0, 3))
            0:       ch = last_chan;
            1:       ch = $urandom_range(0, 255);
            default: ch = $urandom_range(0, 7);
        endcase
        it.kind = ($urandom_range(0, 3) == 0) ? tdssm_pkg::K_LOAD : tdssm_pkg::K_STEP;
        // never step a channel whose weights are still unwritten
        if (!has_weights[ch]) it.kind = tdssm_pkg::K_LOAD;
        it.channel = ch[7:0];
        if ($urandom_range(0, 7) == 0) begin
            it.x_value = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
        end else begin
            it.x_value = 8'($urandom_range(0, 255));
        end
        it.weight_a = pick_weight();
        it.weight_b = pick_weight();
        it.weight_c = pick_weight();
        last_chan   = ch;
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        tdssm_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (expected_steps.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result expected none actual ch %0d y %0d h %0d",
                         $time, o_out.channel_out, o_out.y_value, o_out.state_value);
            end else begin
                want = expected_steps.pop_front();
                compare_field("channel_out", int'(want.channel_out),
                              int'(o_out.channel_out));
                compare_field("y_value", int'($signed(want.y_value)),
                              int'($signed(o_out.y_value)));
                compare_field("state_value", int'($signed(want.state_value)),
                              int'($signed(o_out.state_value)));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: pop high except for random stall bursts
    initial begin
        pop <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        tdssm_pkg::t_in it;
        bit  mode;
        error_count  = 0;
        quiet_cycles = 0;
        packed_now   = 1'b0;
        calm         = 1'b0;
        last_chan    = 0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;

        // full-width weights: saturation at both ends, zero weights
        plan_cfg(1'b0);
        plan_item(tdssm_pkg::K_LOAD, 0, 0, 1, 1, 1);
        plan_item(tdssm_pkg::K_STEP, 0, 127, -1, -1, -1, 1'b1, 127, 127);
        plan_item(tdssm_pkg::K_STEP, 0, 127, -1, -1, -1, 1'b1, 127, 127);
        plan_item(tdssm_pkg::K_LOAD, 255, -128, 127, 127, 127);
        plan_item(tdssm_pkg::K_STEP, 255, -128, 0, 0, 0, 1'b1, -128, -128);
        plan_item(tdssm_pkg::K_LOAD, 1, -128, -128, -128, -128);
        plan_item(tdssm_pkg::K_STEP, 1, -128, 0, 0, 0, 1'b1, -128, 127);
        plan_item(tdssm_pkg::K_STEP, 1, 127, 0, 0, 0, 1'b1, 127, -128);
        plan_item(tdssm_pkg::K_LOAD, 2, 5, 0, 0, 0);
        plan_item(tdssm_pkg::K_STEP, 2, 99, 127, 127, 127, 1'b1, 0, 0);
        plan_item(tdssm_pkg::K_LOAD, 3, 10, 2, -3, -1);
        plan_item(tdssm_pkg::K_STEP, 3, 4, 0, 0, 0);
        plan_item(tdssm_pkg::K_STEP, 3, -7, 0, 0, 0);
        // ternary codes, upper bits of each field set to junk
        plan_cfg(1'b1);
        plan_item(tdssm_pkg::K_LOAD, 4, 50, -3, -2, -86);
        plan_item(tdssm_pkg::K_STEP, 4, 20, 0, 0, 0);
        plan_item(tdssm_pkg::K_LOAD, 5, 3, -4, 127, 1);
        plan_item(tdssm_pkg::K_STEP, 5, 100, 0, 0, 0, 1'b1, 0, 0);
        plan_item(tdssm_pkg::K_LOAD, 6, -128, 1, 1, 2);
        plan_item(tdssm_pkg::K_STEP, 6, -128, 0, 0, 0, 1'b1, 127, -128);
        // weights decoded earlier must survive the mode change
        plan_cfg(1'b0);
        plan_item(tdssm_pkg::K_STEP, 4, -100, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_row) begin
                write_mode(directed_rows[i].cfg_value);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].known,
                          directed_rows[i].y, directed_rows[i].h);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                mode = (p == 0);
            end else begin
                mode = 1'($urandom_range(0, 1));
            end
            write_mode(mode);
            calm = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item(it);
                send_item(it);
            end
        end

        push <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_steps.size() != 0) begin
            error_count++;
            $display("%0t: results outstanding expected 0 actual %0d", $time,
                     expected_steps.size());
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
